>>> src/csalu_pkg.sv
// ----------------------------------------------------------------------------
// csalu_pkg
// Shared types and constants of the overflow-checked signed integer ALU.
// ----------------------------------------------------------------------------
package csalu_pkg;

  // Arithmetic width; operand bits above it are ignored.
  localparam int DATA_WIDTH = 64;
  // Split of a magnitude into a low and a high part for the multiplier.
  localparam int HALF_LO = (DATA_WIDTH + 1) / 2;
  localparam int HALF_HI = DATA_WIDTH - HALF_LO;

  localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_GT  = 4'd5,
    OP_GE  = 4'd6,
    OP_LT  = 4'd7,
    OP_LE  = 4'd8,
    OP_EQ  = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_TYPE = 2'd1,
    ST_OVF  = 2'd2,
    ST_DIV  = 2'd3
  } status_t;

  // Input transaction.
  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
    logic               a_is_integer;
    logic               b_is_integer;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic signed [63:0] value;
    logic               truth;
    logic [1:0]         status;
  } out_t;

  // Work record that travels down the pipeline with each transaction.
  typedef struct packed {
    logic [3:0]            op;
    status_t               status;
    logic                  truth;
    logic [DATA_WIDTH-1:0] value;
    logic [DATA_WIDTH-1:0] a_mag;
    logic [DATA_WIDTH-1:0] b_mag;
    logic                  neg_q;
    logic                  neg_r;
  } rec_t;

endpackage

>>> src/csalu_front.sv
// ----------------------------------------------------------------------------
// csalu_front
// First stage: type check, add and subtract with overflow, comparisons,
// divide checks and operand magnitudes for the multiplier and divider.
// ----------------------------------------------------------------------------
module csalu_front import csalu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  in_t  in_data,
  output logic vld,
  output rec_t rec
);

  logic signed [DATA_WIDTH-1:0] a;
  logic signed [DATA_WIDTH-1:0] b;
  logic signed [DATA_WIDTH-1:0] sum;
  logic signed [DATA_WIDTH-1:0] diff;
  logic                         add_ovf;
  logic                         sub_ovf;
  logic                         div_bad;
  rec_t                         rec_next;

  assign a    = in_data.operand_a[DATA_WIDTH-1:0];
  assign b    = in_data.operand_b[DATA_WIDTH-1:0];
  assign sum  = a + b;
  assign diff = a - b;

  assign add_ovf = (a[DATA_WIDTH-1] == b[DATA_WIDTH-1]) && (sum[DATA_WIDTH-1] != a[DATA_WIDTH-1]);
  assign sub_ovf = (a[DATA_WIDTH-1] != b[DATA_WIDTH-1]) &&
                   (diff[DATA_WIDTH-1] != a[DATA_WIDTH-1]);
  assign div_bad = (b == '0) || ((a == MIN_VAL) && (b == '1));

  // Decode the operation and settle everything that fits in one stage.
  always_comb begin
    rec_next        = '0;
    rec_next.op     = in_data.opcode;
    rec_next.status = ST_OK;
    rec_next.a_mag  = a[DATA_WIDTH-1] ? ({DATA_WIDTH{1'b0}} - a) : a;
    rec_next.b_mag  = b[DATA_WIDTH-1] ? ({DATA_WIDTH{1'b0}} - b) : b;
    rec_next.neg_q  = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
    rec_next.neg_r  = a[DATA_WIDTH-1];
    if (!in_data.a_is_integer || !in_data.b_is_integer) begin
      rec_next.status = ST_TYPE;
    end else begin
      unique case (in_data.opcode)
        OP_ADD: begin
          if (add_ovf) rec_next.status = ST_OVF;
          else         rec_next.value  = sum;
        end
        OP_SUB: begin
          if (sub_ovf) rec_next.status = ST_OVF;
          else         rec_next.value  = diff;
        end
        OP_DIV, OP_MOD: begin
          if (div_bad) rec_next.status = ST_DIV;
        end
        OP_GT:   rec_next.truth = (a > b);
        OP_GE:   rec_next.truth = (a >= b);
        OP_LT:   rec_next.truth = (a < b);
        OP_LE:   rec_next.truth = (a <= b);
        OP_EQ:   rec_next.truth = (a == b);
        default: rec_next.truth = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_valid;
    end
    if (en) begin
      rec <= rec_next;
    end
  end

endmodule

>>> src/csalu_mul.sv
// ----------------------------------------------------------------------------
// csalu_mul
// Four-stage magnitude multiplier with signed overflow check.
// ----------------------------------------------------------------------------
module csalu_mul import csalu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vld_in,
  input  rec_t rec_in,
  output logic vld_out,
  output rec_t rec_out
);

  logic [3:0] vld;
  rec_t       rec1;
  rec_t       rec2;
  rec_t       rec3;

  // Partial products of the two halves.
  logic [2*HALF_LO-1:0]    p0;
  logic [DATA_WIDTH-1:0]   p1;
  logic [DATA_WIDTH-1:0]   p2;
  logic [2*HALF_HI-1:0]    p3;
  logic [2*HALF_LO-1:0]    p0_d;
  logic [2*HALF_HI-1:0]    p3_d;
  logic [DATA_WIDTH:0]     mid;
  logic [2*DATA_WIDTH-1:0] prod;

  logic [DATA_WIDTH-1:0]   lo;
  logic [DATA_WIDTH-1:0]   hi;
  logic [DATA_WIDTH-1:0]   lim;
  logic                    ovf;
  rec_t                    rec_next;

  // Final check on the full product.
  assign hi  = prod[2*DATA_WIDTH-1:DATA_WIDTH];
  assign lo  = prod[DATA_WIDTH-1:0];
  assign lim = rec3.neg_q ? MIN_VAL : MAX_VAL;
  assign ovf = (hi != '0) || (lo > lim);

  always_comb begin
    rec_next = rec3;
    if ((rec3.op == OP_MUL) && (rec3.status == ST_OK)) begin
      if (ovf) rec_next.status = ST_OVF;
      else     rec_next.value  = rec3.neg_q ? ({DATA_WIDTH{1'b0}} - lo) : lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], vld_in};
    end
    if (en) begin
      // Stage one: four narrow products.
      p0   <= rec_in.a_mag[HALF_LO-1:0] * rec_in.b_mag[HALF_LO-1:0];
      p1   <= rec_in.a_mag[HALF_LO-1:0] * rec_in.b_mag[DATA_WIDTH-1:HALF_LO];
      p2   <= rec_in.a_mag[DATA_WIDTH-1:HALF_LO] * rec_in.b_mag[HALF_LO-1:0];
      p3   <= rec_in.a_mag[DATA_WIDTH-1:HALF_LO] * rec_in.b_mag[DATA_WIDTH-1:HALF_LO];
      rec1 <= rec_in;
      // Stage two: middle terms.
      mid  <= {1'b0, p1} + {1'b0, p2};
      p0_d <= p0;
      p3_d <= p3;
      rec2 <= rec1;
      // Stage three: full product.
      prod <= {p3_d, p0_d} + ({{(DATA_WIDTH-1){1'b0}}, mid} << HALF_LO);
      rec3 <= rec2;
      // Stage four: overflow check and sign.
      rec_out <= rec_next;
    end
  end

  assign vld_out = vld[3];

endmodule

>>> src/csalu_div.sv
// ----------------------------------------------------------------------------
// csalu_div
// Restoring divider on magnitudes, one quotient bit per pipeline stage.
// The quotient ends up in a_mag; the remainder comes out separately.
// ----------------------------------------------------------------------------
module csalu_div import csalu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  vld_in,
  input  rec_t                  rec_in,
  output logic                  vld_out,
  output rec_t                  rec_out,
  output logic [DATA_WIDTH-1:0] rem_out
);

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
    rec_t                  rec_prev;
    logic [DATA_WIDTH-1:0] rem_prev;
    logic                  vld_prev;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;
    rec_t                  rec_next;
    logic                  vld;
    rec_t                  rec;
    logic [DATA_WIDTH-1:0] rem;

    if (i == 0) begin : g_first
      assign rec_prev = rec_in;
      assign rem_prev = '0;
      assign vld_prev = vld_in;
    end else begin : g_rest
      assign rec_prev = g_stage[i-1].rec;
      assign rem_prev = g_stage[i-1].rem;
      assign vld_prev = g_stage[i-1].vld;
    end

    // Shift in the next dividend bit and try the subtraction.
    assign trial = {rem_prev, rec_prev.a_mag[DATA_WIDTH-1]};
    assign diff  = trial - {1'b0, rec_prev.b_mag};
    assign fits  = !diff[DATA_WIDTH];

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    always_comb begin
      rec_next       = rec_prev;
      rec_next.a_mag = {rec_prev.a_mag[DATA_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= 1'b0;
      end else if (en) begin
        vld <= vld_prev;
      end
      if (en) begin
        rec <= rec_next;
        rem <= fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      end
    end
  end

  assign vld_out = g_stage[DATA_WIDTH-1].vld;
  assign rec_out = g_stage[DATA_WIDTH-1].rec;
  assign rem_out = g_stage[DATA_WIDTH-1].rem;

endmodule

>>> src/checked_signed_alu_top.sv
// ----------------------------------------------------------------------------
// checked_signed_alu_top
// Overflow-checked signed integer ALU: add, sub, mul, div, mod and compares.
// ----------------------------------------------------------------------------
// The block accepts one transaction every cycle while the output is not stalled
// and returns exactly one result per transaction, in order. The pipeline holds
// one decode stage, four multiplier stages, one divider stage per quotient bit
// and one output register; the divider chain is its longest part. The whole
// pipeline advances whenever the output register is empty or being taken, so
// a stall on the output holds every stage in place.
module checked_signed_alu_top import csalu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic                         en;
  logic                         f_vld;
  rec_t                         f_rec;
  logic                         m_vld;
  rec_t                         m_rec;
  logic                         d_vld;
  rec_t                         d_rec;
  logic [DATA_WIDTH-1:0]        d_rem;
  logic signed [DATA_WIDTH-1:0] res;
  out_t                         out_next;

  // Pipeline advances when the output slot is free or being emptied.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  csalu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .vld      (f_vld),
    .rec      (f_rec)
  );

  csalu_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (f_vld),
    .rec_in  (f_rec),
    .vld_out (m_vld),
    .rec_out (m_rec)
  );

  csalu_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (m_vld),
    .rec_in  (m_rec),
    .vld_out (d_vld),
    .rec_out (d_rec),
    .rem_out (d_rem)
  );

  // Pick the result and apply the sign of quotient or remainder.
  always_comb begin
    res = d_rec.value;
    if (d_rec.op == OP_DIV) begin
      res = d_rec.neg_q ? ({DATA_WIDTH{1'b0}} - d_rec.a_mag) : d_rec.a_mag;
    end else if (d_rec.op == OP_MOD) begin
      res = d_rec.neg_r ? ({DATA_WIDTH{1'b0}} - d_rem) : d_rem;
    end
    out_next        = '0;
    out_next.status = d_rec.status;
    if (d_rec.status == ST_OK) begin
      out_next.value = 64'(res);
      out_next.truth = d_rec.truth;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_vld;
    end
    if (en) begin
      out_data <= out_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A flagged result never carries a value or a truth bit.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_OK) |-> (out_data.value == '0) && !out_data.truth)
    else $error("flagged result carries data");

  // A true comparison only comes from a clean transaction.
  a_truth_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.truth |-> (out_data.status == ST_OK))
    else $error("truth set on flagged result");

  // Nothing leaves the pipeline right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overflow-checked signed ALU testbench
// Drives directed and random operations through the valid/ready ports and
// compares every result against a written-out value or an in-bench model of the
// arithmetic, overflow rules and comparisons, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import csalu_pkg::*;

  localparam int LATENCY    = DATA_WIDTH + 6;
  localparam int RAND_ITEMS = 1230;
  localparam int WATCHDOG   = 20000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  out_t expected_results[$];
  int   error_count;
  bit   calm_phase;
  bit   hold_off_req;
  bit   hold_off_done;
  int   idle_cycles;

  // Directed row: the expected result is only meaningful when has_expect is set.
  typedef struct {
    in_t  item;
    bit   has_expect;
    out_t result;
  } row_t;

  checked_signed_alu_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Compute the result of one operation at 64 bits.
  function automatic out_t alu_result(in_t t);
    logic signed [63:0] a, b;
    logic signed [64:0] wide;
    logic signed [127:0] prod;
    out_t r;
    a = t.operand_a;
    b = t.operand_b;
    r = '0;
    r.status = ST_OK;
    if (!t.a_is_integer || !t.b_is_integer) begin
      r.status = ST_TYPE;
    end else begin
      case (t.opcode)
        OP_ADD, OP_SUB: begin
          wide = (t.opcode == OP_ADD) ? ({a[63], a} + {b[63], b}) : ({a[63], a} - {b[63], b});
          if (wide[64] != wide[63]) r.status = ST_OVF;
          else r.value = wide[63:0];
        end
        OP_MUL: begin
          prod = 128'(a) * 128'(b);
          if (prod != 128'(signed'(prod[63:0]))) r.status = ST_OVF;
          else r.value = prod[63:0];
        end
        OP_DIV, OP_MOD: begin
          if (b == 0 || (a == signed'(MIN_VAL) && b == -64'sd1)) r.status = ST_DIV;
          else if (t.opcode == OP_DIV) r.value = a / b;
          else r.value = a % b;
        end
        OP_GT: r.truth = a > b;
        OP_GE: r.truth = a >= b;
        OP_LT: r.truth = a < b;
        OP_LE: r.truth = a <= b;
        OP_EQ: r.truth = a == b;
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = MIN_VAL;
      1: v = MAX_VAL;
      2: v = '1;
      3: v = '0;
      4: v = 64'($signed($urandom_range(0, 40)) - 20);
      5: v = {{32{1'b0}}, $urandom()} ^ {64{$urandom_range(0, 1) == 1}};
      default: v = {$urandom(), $urandom()};
    endcase
    return v;
  endfunction

  // Send one transaction and record its expected result.
  task automatic send_item(in_t t, bit use_given, out_t given, bit allow_idle);
    if (allow_idle && !calm_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    expected_results.push_back(use_given ? given : alu_result(t));
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender process.
  initial begin
    row_t rows[$];
    row_t row;
    in_t  t;
    out_t none;
    int   drain;
    error_count   = 0;
    calm_phase    = 1'b0;
    hold_off_req  = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    none = '0;

    // Directed rows; the obvious outcomes are written out.
    rows.push_back('{'{OP_ADD, MAX_VAL, 64'sd1, 1'b1, 1'b1}, 1, '{0, 0, ST_OVF}});
    rows.push_back('{'{OP_ADD, MIN_VAL, '1, 1'b1, 1'b1}, 1, '{0, 0, ST_OVF}});
    rows.push_back('{'{OP_ADD, MAX_VAL, MIN_VAL, 1'b1, 1'b1}, 1, '{-1, 0, ST_OK}});
    rows.push_back('{'{OP_SUB, MIN_VAL, 64'sd1, 1'b1, 1'b1}, 1, '{0, 0, ST_OVF}});
    rows.push_back('{'{OP_SUB, 64'sd0, MIN_VAL, 1'b1, 1'b1}, 1, '{0, 0, ST_OVF}});
    rows.push_back('{'{OP_SUB, '1, MAX_VAL, 1'b1, 1'b1}, 1, '{MIN_VAL, 0, ST_OK}});
    rows.push_back('{'{OP_MUL, MIN_VAL, '1, 1'b1, 1'b1}, 1, '{0, 0, ST_OVF}});
    rows.push_back('{'{OP_MUL, MIN_VAL, 64'sd1, 1'b1, 1'b1}, 1, '{MIN_VAL, 0, ST_OK}});
    rows.push_back('{'{OP_MUL, 64'sh1_0000_0000, 64'sh8000_0000, 1'b1, 1'b1}, 0, none});
    rows.push_back('{'{OP_MUL, 64'sh1_0000_0000, 64'sh1_0000_0000, 1'b1, 1'b1}, 1,
                     '{0, 0, ST_OVF}});
    rows.push_back('{'{OP_DIV, 64'sd7, 64'sd0, 1'b1, 1'b1}, 1, '{0, 0, ST_DIV}});
    rows.push_back('{'{OP_DIV, MIN_VAL, '1, 1'b1, 1'b1}, 1, '{0, 0, ST_DIV}});
    rows.push_back('{'{OP_MOD, MIN_VAL, '1, 1'b1, 1'b1}, 1, '{0, 0, ST_DIV}});
    rows.push_back('{'{OP_MOD, 64'sd5, 64'sd0, 1'b1, 1'b1}, 1, '{0, 0, ST_DIV}});
    rows.push_back('{'{OP_DIV, -64'sd7, 64'sd2, 1'b1, 1'b1}, 1, '{-3, 0, ST_OK}});
    rows.push_back('{'{OP_MOD, -64'sd7, 64'sd2, 1'b1, 1'b1}, 1, '{-1, 0, ST_OK}});
    rows.push_back('{'{OP_GT, MAX_VAL, MIN_VAL, 1'b1, 1'b1}, 1, '{0, 1, ST_OK}});
    rows.push_back('{'{OP_GE, MIN_VAL, MIN_VAL, 1'b1, 1'b1}, 1, '{0, 1, ST_OK}});
    rows.push_back('{'{OP_LT, MAX_VAL, MIN_VAL, 1'b1, 1'b1}, 1, '{0, 0, ST_OK}});
    rows.push_back('{'{OP_LE, '1, 64'sd0, 1'b1, 1'b1}, 1, '{0, 1, ST_OK}});
    rows.push_back('{'{OP_EQ, MAX_VAL, MAX_VAL, 1'b1, 1'b1}, 1, '{0, 1, ST_OK}});
    rows.push_back('{'{OP_ADD, 64'sd1, 64'sd1, 1'b0, 1'b1}, 1, '{0, 0, ST_TYPE}});
    rows.push_back('{'{4'd15, 64'sd1, 64'sd1, 1'b1, 1'b0}, 1, '{0, 0, ST_TYPE}});
    rows.push_back('{'{4'd10, MAX_VAL, MIN_VAL, 1'b1, 1'b1}, 1, '{0, 0, ST_OK}});
    rows.push_back('{'{4'd15, '1, '1, 1'b1, 1'b1}, 1, '{0, 0, ST_OK}});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.item, row.has_expect, row.result, 1'b1);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // Long receiver hold-off: keep offering items so the pipeline fills.
      if (n == 200) hold_off_req = 1'b1;
      // Sender pause until every result is back.
      if (n == 500) begin
        in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        @(posedge clk);
      end
      if (n == RAND_ITEMS - 150) calm_phase = 1'b1;
      t.opcode       = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                                    : 4'($urandom_range(0, 9));
      t.operand_a    = rand64();
      t.operand_b    = rand64();
      if ($urandom_range(0, 9) == 0) t.operand_b = t.operand_a;
      t.a_is_integer = $urandom_range(0, 15) != 0;
      t.b_is_integer = $urandom_range(0, 15) != 0;
      send_item(t, 1'b0, none, 1'b1);
    end
    in_valid <= 1'b0;

    wait (expected_results.size() == 0);
    drain = 0;
    while (drain < LATENCY + 10) begin
      @(posedge clk);
      drain++;
    end
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Receiver: random stall bursts plus one long hold-off.
  initial begin
    out_ready <= 1'b0;
    hold_off_done = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_ready <= 1'b0;
        repeat (3 * LATENCY) @(posedge clk);
      end
      if (!calm_phase && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.value, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.value !== want.value)
          report_mismatch("value", out_data.value, want.value);
        if (out_data.truth !== want.truth)
          report_mismatch("truth", 64'(out_data.truth), 64'(want.truth));
        if (out_data.status !== want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

endmodule

>>> filelist.f
src/csalu_pkg.sv
src/csalu_front.sv
src/csalu_mul.sv
src/csalu_div.sv
src/checked_signed_alu_top.sv
test/testbench.sv
